### src/tcpu_pkg.sv
// Shared types and constants for the tricritical contact process update block.
// Used by tcpu_ctrl, tcpu_dp and tricritical_contact_process_update_top.
// No dependencies.
package tcpu_pkg;

    localparam int TCPU_SIDE = 128;

    localparam int KIND_W    = 2;
    localparam int COORD_W   = 7;
    localparam int RAND_W    = 16;
    localparam int PROB_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_PROB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_PROB  = 1'b1;

    localparam logic [PROB_W-1:0] BIRTH_PROB_RST = 16'd19595;
    localparam logic [PROB_W-1:0] PAIR_PROB_RST  = 16'd63570;

    // Cumulative thresholds in steps of 0.1666 for the six pair candidates.
    localparam int PAIR_THR_N = 5;
    localparam logic [RAND_W-1:0] PAIR_THR [PAIR_THR_N] =
        '{16'd10918, 16'd21836, 16'd32754, 16'd43673, 16'd54591};

    typedef struct packed {
        logic clear;
        logic capture;
        logic quot;
        logic reduce;
        logic site;
        logic nbr;
        logic finish;
    } tcpu_cmd_t;

    typedef struct packed {
        logic clear_last;
    } tcpu_status_t;

endpackage

### src/tcpu_ctrl.sv
// Sequencing state machine of the contact process update block.
// Depends on tcpu_pkg; drives the command struct of tcpu_dp and the
// handshake signals of both channels.
module tcpu_ctrl
    import tcpu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  tcpu_status_t status,
    output tcpu_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_QUOT   = 7'b0000100,
        ST_REDUCE = 7'b0001000,
        ST_SITE   = 7'b0010000,
        ST_NBR    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_hold;

    assign out_hold = out_valid_reg && out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                cmd.quot   = 1'b1;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = ST_SITE;
            end
            ST_SITE:
            begin
                cmd.site   = 1'b1;
                state_next = ST_NBR;
            end
            ST_NBR:
            begin
                cmd.nbr    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // The result waits here while the previous one is still held.
                if (!out_hold)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/tcpu_dp.sv
// Datapath of the contact process update block: configuration registers,
// coordinate reduction, lattice memory, decision logic and result register.
// Depends on tcpu_pkg; controlled by tcpu_ctrl through tcpu_cmd_t.
module tcpu_dp
    import tcpu_pkg::*;
#(
    parameter int SIDE = TCPU_SIDE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcpu_cmd_t            cmd,
    output tcpu_status_t         status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PROB_W-1:0]    cfg_data,
    input  logic [KIND_W-1:0]    kind,
    input  logic [COORD_W-1:0]   row,
    input  logic [COORD_W-1:0]   col,
    input  logic                 write_value,
    input  logic [RAND_W-1:0]    rand_main,
    input  logic [RAND_W-1:0]    rand_aux,
    input  logic [RAND_W-1:0]    rand_dir,
    input  logic [RAND_W-1:0]    rand_pair,
    output logic                 read_value,
    output logic                 changed,
    output logic [COORD_W-1:0]   changed_row,
    output logic [COORD_W-1:0]   changed_col,
    output logic                 changed_value
);

    localparam int IDX_W   = $clog2(SIDE);
    localparam int CELLS   = SIDE * SIDE;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int QUOT_SH = 20;
    // Rounded-up reciprocal; exact quotient for every 7-bit coordinate.
    localparam int RECIP   = ((1 << QUOT_SH) + SIDE - 1) / SIDE;

    localparam logic [IDX_W-1:0]  SIDE_MAX  = IDX_W'(SIDE - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

    localparam logic [1:0] DIR_ROW_DEC = 2'd0;
    localparam logic [1:0] DIR_ROW_INC = 2'd1;
    localparam logic [1:0] DIR_COL_DEC = 2'd2;
    localparam logic [1:0] DIR_COL_INC = 2'd3;

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] v);
        return (v == '0) ? SIDE_MAX : v - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
        return (v == SIDE_MAX) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        logic [31:0] a;
        a = 32'(r) * 32'(SIDE) + 32'(c);
        return a[ADDR_W-1:0];
    endfunction

    // Configuration.
    logic [PROB_W-1:0] birth_prob_reg;
    logic [PROB_W-1:0] pair_prob_reg;

    // Captured item.
    logic [KIND_W-1:0]  kind_reg;
    logic [COORD_W-1:0] row_in_reg;
    logic [COORD_W-1:0] col_in_reg;
    logic               wv_reg;
    logic [RAND_W-1:0]  rmain_reg;
    logic [RAND_W-1:0]  raux_reg;
    logic [1:0]         dir_reg;
    logic [RAND_W-1:0]  rpair_reg;

    // Coordinate reduction.
    logic [31:0]        row_prod;
    logic [31:0]        col_prod;
    logic [COORD_W-1:0] row_q_reg;
    logic [COORD_W-1:0] col_q_reg;
    logic [31:0]        row_rem;
    logic [31:0]        col_rem;
    logic [IDX_W-1:0]   r_reg;
    logic [IDX_W-1:0]   c_reg;
    logic [IDX_W-1:0]   nr_next;
    logic [IDX_W-1:0]   nc_next;
    logic [IDX_W-1:0]   nr_reg;
    logic [IDX_W-1:0]   nc_reg;

    // Lattice memory.
    logic              lattice_mem [CELLS];
    logic              mem_rd_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_data;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              site_bit_reg;
    logic              wr_pend_reg;
    logic [IDX_W-1:0]  wr_r_reg;
    logic [IDX_W-1:0]  wr_c_reg;
    logic              wr_v_reg;

    // Decision.
    logic [IDX_W-1:0] cand_r [8];
    logic [IDX_W-1:0] cand_c [8];
    logic [2:0]       excl_a;
    logic [2:0]       excl_b;
    logic [2:0]       pick;
    logic [2:0]       cnt;
    logic [2:0]       sel;
    logic [PROB_W:0]  death_sum;
    logic             ch;
    logic [IDX_W-1:0] cr;
    logic [IDX_W-1:0] cc;
    logic             cv;
    logic             rv;

    // Result register.
    logic               read_value_reg;
    logic               changed_reg;
    logic [COORD_W-1:0] changed_row_reg;
    logic [COORD_W-1:0] changed_col_reg;
    logic               changed_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            birth_prob_reg <= BIRTH_PROB_RST;
            pair_prob_reg  <= PAIR_PROB_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIRTH_PROB: birth_prob_reg <= cfg_data;
                CFG_PAIR_PROB:  pair_prob_reg  <= cfg_data;
                default:        birth_prob_reg <= birth_prob_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            row_in_reg <= row;
            col_in_reg <= col;
            wv_reg     <= write_value;
            rmain_reg  <= rand_main;
            raux_reg   <= rand_aux;
            dir_reg    <= rand_dir[RAND_W-1:RAND_W-2];
            rpair_reg  <= rand_pair;
        end
    end

    // Coordinates are reduced modulo SIDE in two registered steps.
    assign row_prod = 32'(row_in_reg) * 32'(RECIP);
    assign col_prod = 32'(col_in_reg) * 32'(RECIP);
    assign row_rem  = 32'(row_in_reg) - 32'(row_q_reg) * 32'(SIDE);
    assign col_rem  = 32'(col_in_reg) - 32'(col_q_reg) * 32'(SIDE);

    always_comb
    begin
        nr_next = r_reg;
        nc_next = c_reg;
        case (dir_reg)
            DIR_ROW_DEC: nr_next = wrap_dec(r_reg);
            DIR_ROW_INC: nr_next = wrap_inc(r_reg);
            DIR_COL_DEC: nc_next = wrap_dec(c_reg);
            default:     nc_next = wrap_inc(c_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.quot)
        begin
            row_q_reg <= row_prod[QUOT_SH+COORD_W-1:QUOT_SH];
            col_q_reg <= col_prod[QUOT_SH+COORD_W-1:QUOT_SH];
        end
        if (cmd.reduce)
        begin
            r_reg <= row_rem[IDX_W-1:0];
            c_reg <= col_rem[IDX_W-1:0];
        end
        if (cmd.site)
        begin
            nr_reg <= nr_next;
            nc_reg <= nc_next;
        end
        if (cmd.nbr)
        begin
            site_bit_reg <= mem_rd_reg;
        end
    end

    // Memory access: the site is read in the site step, its neighbor in the
    // neighbor step; an update's write lands in the cycle after the result.
    assign rd_addr = cmd.nbr ? cell_addr(nr_reg, nc_reg) : cell_addr(r_reg, c_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = 1'b0;
        if (cmd.clear)
        begin
            wr_en = 1'b1;
        end
        else if (wr_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(wr_r_reg, wr_c_reg);
            wr_data = wr_v_reg;
        end
        else if (cmd.site && kind_reg == KIND_WRITE)
        begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(r_reg, c_reg);
            wr_data = wv_reg;
        end
    end

    // The read register holds the neighbor bit while the result step waits.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lattice_mem[wr_addr] <= wr_data;
        end
        if (cmd.site || cmd.nbr)
        begin
            mem_rd_reg <= lattice_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            wr_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            wr_pend_reg <= cmd.finish && ch;
        end
    end

    assign status.clear_last = (clr_addr_reg == CELL_LAST);

    // Pair growth candidates: the site's neighbors, then the partner's,
    // leaving out each member of the pair.
    always_comb
    begin
        cand_r[0] = wrap_dec(r_reg);  cand_c[0] = c_reg;
        cand_r[1] = wrap_inc(r_reg);  cand_c[1] = c_reg;
        cand_r[2] = r_reg;            cand_c[2] = wrap_inc(c_reg);
        cand_r[3] = r_reg;            cand_c[3] = wrap_dec(c_reg);
        cand_r[4] = wrap_dec(nr_reg); cand_c[4] = nc_reg;
        cand_r[5] = wrap_inc(nr_reg); cand_c[5] = nc_reg;
        cand_r[6] = nr_reg;           cand_c[6] = wrap_inc(nc_reg);
        cand_r[7] = nr_reg;           cand_c[7] = wrap_dec(nc_reg);
    end

    always_comb
    begin
        case (dir_reg)
            DIR_ROW_DEC: begin excl_a = 3'd0; excl_b = 3'd5; end
            DIR_ROW_INC: begin excl_a = 3'd1; excl_b = 3'd4; end
            DIR_COL_DEC: begin excl_a = 3'd3; excl_b = 3'd6; end
            default:     begin excl_a = 3'd2; excl_b = 3'd7; end
        endcase
    end

    always_comb
    begin
        pick = 3'd5;
        for (int k = PAIR_THR_N - 1; k >= 0; k--)
        begin
            if (rpair_reg <= PAIR_THR[k])
            begin
                pick = 3'(k);
            end
        end
    end

    always_comb
    begin
        cnt = '0;
        sel = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (3'(k) != excl_a && 3'(k) != excl_b)
            begin
                if (cnt == pick)
                begin
                    sel = 3'(k);
                end
                cnt = cnt + 1'b1;
            end
        end
    end

    assign death_sum = {1'b0, raux_reg} + {1'b0, birth_prob_reg};

    always_comb
    begin
        ch = 1'b0;
        cr = '0;
        cc = '0;
        cv = 1'b0;
        rv = (kind_reg == KIND_READ) ? site_bit_reg : 1'b0;
        if (kind_reg == KIND_UPDATE && site_bit_reg)
        begin
            // mem_rd_reg holds the neighbor cell during the result step.
            if (!mem_rd_reg)
            begin
                ch = 1'b1;
                if (rmain_reg < birth_prob_reg)
                begin
                    cr = nr_reg;
                    cc = nc_reg;
                    cv = 1'b1;
                end
                else
                begin
                    cr = r_reg;
                    cc = c_reg;
                end
            end
            else if (rmain_reg < pair_prob_reg)
            begin
                ch = 1'b1;
                cr = cand_r[sel];
                cc = cand_c[sel];
                cv = 1'b1;
            end
            else if (!death_sum[PROB_W])
            begin
                ch = 1'b1;
                cr = r_reg;
                cc = c_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            wr_r_reg          <= cr;
            wr_c_reg          <= cc;
            wr_v_reg          <= cv;
            read_value_reg    <= rv;
            changed_reg       <= ch;
            changed_row_reg   <= COORD_W'(cr);
            changed_col_reg   <= COORD_W'(cc);
            changed_value_reg <= cv;
        end
    end

    assign read_value    = read_value_reg;
    assign changed       = changed_reg;
    assign changed_row   = changed_row_reg;
    assign changed_col   = changed_col_reg;
    assign changed_value = changed_value_reg;

endmodule

### src/tricritical_contact_process_update_top.sv
// Tricritical contact process update: an accepted transaction passes through
// the quotient, reduction, site, neighbor and result steps in that order, with
// in_stall high until it leaves the result step, which waits while the previous
// result is still held; the steps follow from the single read port of the lattice
// memory (site, then neighbor) and the two-step coordinate reduction. After reset
// a clearing pass writes every lattice cell empty, with in_stall high; configuration writes are taken throughout.
module tricritical_contact_process_update_top
    import tcpu_pkg::*;
#(
    parameter int SIDE = TCPU_SIDE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PROB_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KIND_W-1:0]    kind,
    input  logic [COORD_W-1:0]   row,
    input  logic [COORD_W-1:0]   col,
    input  logic                 write_value,
    input  logic [RAND_W-1:0]    rand_main,
    input  logic [RAND_W-1:0]    rand_aux,
    input  logic [RAND_W-1:0]    rand_dir,
    input  logic [RAND_W-1:0]    rand_pair,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 read_value,
    output logic                 changed,
    output logic [COORD_W-1:0]   changed_row,
    output logic [COORD_W-1:0]   changed_col,
    output logic                 changed_value
);

    tcpu_cmd_t    cmd;
    tcpu_status_t status;

    tcpu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tcpu_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .row           (row),
        .col           (col),
        .write_value   (write_value),
        .rand_main     (rand_main),
        .rand_aux      (rand_aux),
        .rand_dir      (rand_dir),
        .rand_pair     (rand_pair),
        .read_value    (read_value),
        .changed       (changed),
        .changed_row   (changed_row),
        .changed_col   (changed_col),
        .changed_value (changed_value)
    );

    // The block works on one transaction at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a transaction is in progress");

    // With no result pending, out_valid rises once an accepted transaction has left the result step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |-> ##6 out_valid)
        else $error("result did not appear on schedule");

    // A set read value never comes with a change, and a written value implies a change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!(read_value && changed) && (changed || !changed_value)))
        else $error("inconsistent result fields");

endmodule
